[rtl/core/path_time_param_interpolator_macros.svh]
// Assertion macros used by the interpolator checker
`ifndef PATH_TIME_PARAM_INTERPOLATOR_MACROS_SVH
`define PATH_TIME_PARAM_INTERPOLATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PTPI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptpi assertion failed");

// antecedent implies consequent in the next cycle
`define PTPI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptpi assertion failed");

`endif

[rtl/core/ptpi_pkg.sv]
// Package: types, constants and helpers of the path-time interpolator
`default_nettype none
package ptpi_pkg;

    localparam int VAL_W     = 32;
    localparam int SEG_W     = 8;
    localparam int PER_W     = 31;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;
    localparam int WORD_W    = 4 * VAL_W;
    localparam int ROOT_W    = 24;
    localparam int DIVR_W    = 25;
    localparam int OPND_W    = 50;
    localparam int REM_W     = 27;
    localparam int STEP_W    = 6;
    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 50;
    localparam int WIDE_W    = 52;
    localparam int PROD_W    = 66;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic signed [WIDE_W-1:0] SAT_HI = 52'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -52'sd2147483648;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_PUSH  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_GO,
        S_SQ_WAIT,
        S_DV_GO,
        S_DV_WAIT,
        S_Q_RD,
        S_Q_CHK,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } dsq_cmd_t;

    typedef struct packed {
        logic              done;
        logic [OPND_W-1:0] q;
    } dsq_rsp_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [VAL_W-1:0] r;
        if (x > SAT_HI)
            r = SAT_HI[VAL_W-1:0];
        else if (x < SAT_LO)
            r = SAT_LO[VAL_W-1:0];
        else
            r = x[VAL_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/ptpi_if.sv]
// Handshake channel interfaces for the interpolator
`default_nettype none
interface ptpi_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] waypoint_position;
    logic signed [31:0] speed_squared;
    logic signed [31:0] waypoint_accel;
    logic signed [31:0] query_time;

    modport source (output valid, kind, waypoint_position, speed_squared,
                    waypoint_accel, query_time, input ready);
    modport sink (input valid, kind, waypoint_position, speed_squared,
                  waypoint_accel, query_time, output ready);
endinterface

interface ptpi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_out;
    logic signed [31:0] velocity_out;
    logic signed [31:0] accel_out;
    logic [30:0]        total_period;
    logic signed [7:0]  segment;
    logic [1:0]         status;

    modport source (output valid, position_out, velocity_out, accel_out,
                    total_period, segment, status, input ready);
    modport sink (input valid, position_out, velocity_out, accel_out,
                  total_period, segment, status, output ready);
endinterface
`default_nettype wire

[rtl/core/path_time_param_interpolator.sv]
// Top level: waypoint table, push/query sequencer, shared multiplier
//
//  channel | dir | beat contents
//  item    | in  | kind, waypoint_position, speed_squared, waypoint_accel, query_time
//  result  | out | position_out, velocity_out, accel_out, total_period, segment, status
//
// Clear and idle kinds go straight to the result state. Push: 24-step square root
// (when speed_squared > 0) and 50-step divide in the shared bit-serial unit.
// Query: read and check states per stamp on the single read port, then S_M1 to S_M5.
// One item at a time; result beat held in an output register until taken.
// Reset empties the table; table contents are not cleared.
`default_nettype none
module path_time_param_interpolator
    import ptpi_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    ptpi_in_if.sink   item,
    ptpi_out_if.source result
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    state_t state_reg, state_next;

    logic [CW-1:0]           count_reg;
    logic                    out_valid_reg;
    kind_t                   kind_reg;
    logic                    push_ok_reg;
    logic signed [VAL_W-1:0] in_pos_reg, in_sq_reg, in_acc_reg, tq_reg;
    logic signed [VAL_W-1:0] last_pos_reg, last_speed_reg, last_time_reg;
    logic signed [VAL_W-1:0] v_reg, t_new_reg, dt_reg;
    logic [CW-1:0]           scan_idx_reg;
    logic [WORD_W-1:0]       word_reg, rd_word_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [OPND_W-1:0] pv_reg, pu_reg;
    logic signed [VAL_W-1:0] r_pos_reg, r_vel_reg, r_acc_reg;
    logic [SEG_W-1:0]        r_seg_reg;
    logic [STAT_W-1:0]       r_stat_reg;
    logic signed [VAL_W-1:0] o_pos_reg, o_vel_reg, o_acc_reg;
    logic [PER_W-1:0]        o_per_reg;
    logic [SEG_W-1:0]        o_seg_reg;
    logic [STAT_W-1:0]       o_stat_reg;

    logic [WORD_W-1:0] mem [MAX_POINTS];

    dsq_cmd_t          dsq_cmd;
    dsq_rsp_t          dsq_rsp;
    logic [OPND_W-1:0] dsq_opnd;
    logic [DIVR_W-1:0] dsq_divr;

    logic                    accept, load_out, mem_we;
    logic signed [VAL_W:0]   ds;
    logic [VAL_W:0]          abs_ds;
    logic signed [VAL_W-1:0] w_pos, w_spd, w_acc, w_time, rd_time;
    logic signed [VAL_W-1:0] dt_cmb;
    logic [VAL_W-1:0]        abs_dt;
    logic [VAL_W-1:0]        dt2;
    logic signed [VAL_W:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [CW+7:0]           idx_wide, idx_m1;
    logic signed [WIDE_W-1:0] step_t, pos_sum, vel_sum;
    logic signed [VAL_W-1:0] per_t;
    logic                    per_zero;

    assign accept     = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign load_out   = (state_reg == S_OUT) && (!out_valid_reg || result.ready);
    assign mem_we     = load_out && push_ok_reg;

    assign w_pos   = word_reg[4*VAL_W-1 -: VAL_W];
    assign w_spd   = word_reg[3*VAL_W-1 -: VAL_W];
    assign w_acc   = word_reg[2*VAL_W-1 -: VAL_W];
    assign w_time  = word_reg[VAL_W-1:0];
    assign rd_time = rd_word_reg[VAL_W-1:0];

    assign ds       = (VAL_W+1)'(in_pos_reg) - (VAL_W+1)'(last_pos_reg);
    assign abs_ds   = ds[VAL_W] ? (VAL_W+1)'(-ds) : ds;
    assign dt_cmb   = sat32(WIDE_W'(tq_reg) - WIDE_W'(w_time));
    assign abs_dt   = dt_reg[VAL_W-1] ? VAL_W'(-dt_reg) : dt_reg;
    assign dt2      = (|prod_reg[PROD_W-1:VAL_W+15]) ? SAT_HI[VAL_W-1:0]
                                                     : {1'b0, prod_reg[VAL_W+14:16]};
    assign idx_wide = {8'b0, scan_idx_reg};
    assign idx_m1   = idx_wide - (CW+8)'(1);
    assign step_t   = WIDE_W'(last_time_reg)
                    + (abs_ds[VAL_W] || ds[VAL_W] ? -WIDE_W'(signed'({2'b0, dsq_rsp.q}))
                                                  :  WIDE_W'(signed'({2'b0, dsq_rsp.q})));
    assign pos_sum  = WIDE_W'(w_pos) + WIDE_W'(pv_reg)
                    + WIDE_W'(signed'(prod_reg[PROD_W-1:17]));
    assign vel_sum  = WIDE_W'(w_spd) + WIDE_W'(pu_reg);
    assign mul_p    = mul_a * mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M1:
            begin
                mul_a = (VAL_W+1)'(w_spd);
                mul_b = (VAL_W+1)'(dt_reg);
            end
            S_M2:
            begin
                mul_a = (VAL_W+1)'(w_acc);
                mul_b = (VAL_W+1)'(dt_reg);
            end
            S_M3:
            begin
                mul_a = signed'({1'b0, abs_dt});
                mul_b = signed'({1'b0, abs_dt});
            end
            S_M4:
            begin
                mul_a = (VAL_W+1)'(w_acc);
                mul_b = signed'({1'b0, dt2});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // period after the step
    always_comb
    begin
        if (kind_reg == KIND_CLEAR)
        begin
            per_t    = '0;
            per_zero = 1'b1;
        end
        else if (push_ok_reg)
        begin
            per_t    = t_new_reg;
            per_zero = 1'b0;
        end
        else
        begin
            per_t    = last_time_reg;
            per_zero = (count_reg == '0);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dsq_cmd    = '0;
        dsq_opnd   = {1'b0, in_sq_reg[VAL_W-2:0], 18'b0};
        dsq_divr   = last_speed_reg[DIVR_W-1:0] + v_reg[DIVR_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(item.kind))
                        KIND_PUSH:
                        begin
                            if (count_reg == CW'(MAX_POINTS))
                                state_next = S_OUT;
                            else if (item.speed_squared > 0)
                                state_next = S_SQ_GO;
                            else if (count_reg == '0)
                                state_next = S_OUT;
                            else
                                state_next = S_DV_GO;
                        end
                        KIND_QUERY:
                            state_next = (count_reg == '0) ? S_OUT : S_Q_RD;
                        default:
                            state_next = S_OUT;
                    endcase
                end
            end
            S_SQ_GO:
            begin
                dsq_cmd.start  = 1'b1;
                dsq_cmd.is_div = 1'b0;
                state_next     = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (dsq_rsp.done)
                    state_next = (count_reg == '0) ? S_OUT : S_DV_GO;
            end
            S_DV_GO:
            begin
                dsq_cmd.start  = 1'b1;
                dsq_cmd.is_div = 1'b1;
                dsq_opnd       = {abs_ds, 17'b0};
                state_next     = S_DV_WAIT;
            end
            S_DV_WAIT:
            begin
                if (dsq_rsp.done)
                    state_next = S_OUT;
            end
            S_Q_RD:
                state_next = S_Q_CHK;
            S_Q_CHK:
            begin
                if (rd_time > tq_reg)
                    state_next = (scan_idx_reg == '0) ? S_OUT : S_M1;
                else if (scan_idx_reg == count_reg - CW'(1))
                    state_next = S_OUT;
                else
                    state_next = S_Q_RD;
            end
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_M4;
            S_M4:    state_next = S_M5;
            S_M5:    state_next = S_OUT;
            S_OUT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    ptpi_dsq u_dsq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (dsq_cmd),
        .opnd    (dsq_opnd),
        .divisor (dsq_divr),
        .rsp     (dsq_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (kind_reg == KIND_CLEAR)
                    count_reg <= '0;
                else if (push_ok_reg)
                    count_reg <= count_reg + CW'(1);
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[AW-1:0]] <= {in_pos_reg, v_reg, in_acc_reg, t_new_reg};
        rd_word_reg <= mem[scan_idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_reg     <= kind_t'(item.kind);
                    in_pos_reg   <= item.waypoint_position;
                    in_sq_reg    <= item.speed_squared;
                    in_acc_reg   <= item.waypoint_accel;
                    tq_reg       <= item.query_time;
                    v_reg        <= VAL_W'(1);
                    t_new_reg    <= '0;
                    scan_idx_reg <= '0;
                    r_pos_reg    <= '0;
                    r_vel_reg    <= '0;
                    r_acc_reg    <= '0;
                    r_seg_reg    <= '1;
                    r_stat_reg   <= STAT_OK;
                    push_ok_reg  <= 1'b0;
                    if (kind_t'(item.kind) == KIND_PUSH)
                    begin
                        if (count_reg == CW'(MAX_POINTS))
                            r_stat_reg <= STAT_FULL;
                        else
                            push_ok_reg <= 1'b1;
                    end
                    else if (kind_t'(item.kind) == KIND_QUERY && count_reg == '0)
                        r_stat_reg <= STAT_EMPTY;
                end
            end
            S_SQ_WAIT:
            begin
                if (dsq_rsp.done)
                    v_reg <= VAL_W'(dsq_rsp.q[ROOT_W-1:0]);
            end
            S_DV_WAIT:
            begin
                if (dsq_rsp.done)
                    t_new_reg <= sat32(step_t);
            end
            S_Q_CHK:
            begin
                if (rd_time > tq_reg)
                begin
                    r_seg_reg <= idx_m1[SEG_W-1:0];
                    dt_reg    <= dt_cmb;
                end
                else
                begin
                    word_reg <= rd_word_reg;
                    if (scan_idx_reg == count_reg - CW'(1))
                    begin
                        r_seg_reg <= idx_wide[SEG_W-1:0];
                        r_pos_reg <= last_pos_reg;
                    end
                    else
                        scan_idx_reg <= scan_idx_reg + CW'(1);
                end
            end
            S_M1:
                prod_reg <= mul_p;
            S_M2:
            begin
                pv_reg   <= prod_reg[PROD_W-1:16];
                prod_reg <= mul_p;
            end
            S_M3:
            begin
                pu_reg   <= prod_reg[PROD_W-1:16];
                prod_reg <= mul_p;
            end
            S_M4:
                prod_reg <= mul_p;
            S_M5:
            begin
                r_pos_reg <= sat32(pos_sum);
                r_vel_reg <= sat32(vel_sum);
                r_acc_reg <= w_acc;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    o_pos_reg  <= r_pos_reg;
                    o_vel_reg  <= r_vel_reg;
                    o_acc_reg  <= r_acc_reg;
                    o_seg_reg  <= r_seg_reg;
                    o_stat_reg <= r_stat_reg;
                    o_per_reg  <= (per_zero || per_t[VAL_W-1]) ? '0 : per_t[PER_W-1:0];
                    if (push_ok_reg)
                    begin
                        last_pos_reg   <= in_pos_reg;
                        last_speed_reg <= v_reg;
                        last_time_reg  <= t_new_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.valid        = out_valid_reg;
    assign result.position_out = o_pos_reg;
    assign result.velocity_out = o_vel_reg;
    assign result.accel_out    = o_acc_reg;
    assign result.total_period = o_per_reg;
    assign result.segment      = o_seg_reg;
    assign result.status       = o_stat_reg;

endmodule
`default_nettype wire

[rtl/core/ptpi_dsq.sv]
// Shared bit-serial unit: square root (two bits a step) or division (one bit a step)
`default_nettype none
module ptpi_dsq
    import ptpi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dsq_cmd_t          cmd,
    input  wire logic [OPND_W-1:0] opnd,
    input  wire logic [DIVR_W-1:0] divisor,
    output dsq_rsp_t               rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic              is_div_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [OPND_W-1:0] opnd_reg;
    logic [OPND_W-1:0] q_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIVR_W-1:0] divr_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  diff;
    logic              ge;
    logic [STEP_W-1:0] last_step;

    always_comb
    begin
        if (is_div_reg)
        begin
            rem_sh    = {rem_reg[REM_W-2:0], opnd_reg[OPND_W-1]};
            trial     = REM_W'(divr_reg);
            last_step = STEP_W'(DIV_STEPS - 1);
        end
        else
        begin
            rem_sh    = {rem_reg[REM_W-3:0], opnd_reg[OPND_W-1 -: 2]};
            trial     = {1'b0, q_reg[ROOT_W-1:0], 2'b01};
            last_step = STEP_W'(SQRT_STEPS - 1);
        end
        ge   = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
                busy_reg <= 1'b1;
            else if (busy_reg && cnt_reg == last_step)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            opnd_reg   <= opnd;
            divr_reg   <= divisor;
            rem_reg    <= '0;
            q_reg      <= '0;
            is_div_reg <= cmd.is_div;
            cnt_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff : rem_sh;
            q_reg    <= {q_reg[OPND_W-2:0], ge};
            opnd_reg <= is_div_reg ? {opnd_reg[OPND_W-2:0], 1'b0}
                                   : {opnd_reg[OPND_W-3:0], 2'b00};
            cnt_reg  <= cnt_reg + STEP_W'(1);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule
`default_nettype wire

[rtl/core/ptpi_checker.sv]
// Port-level checker for the interpolator, bound to the top level
`default_nettype none
`include "path_time_param_interpolator_macros.svh"
module ptpi_checker
    import ptpi_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic signed [VAL_W-1:0] position_out,
    input wire logic signed [VAL_W-1:0] velocity_out,
    input wire logic signed [VAL_W-1:0] accel_out,
    input wire logic [PER_W-1:0]        total_period,
    input wire logic [SEG_W-1:0]        segment,
    input wire logic [STAT_W-1:0]       status
);

    `PTPI_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `PTPI_ASSERT_IMP(a_stat, clk, rst_n, out_valid, status == STAT_OK || status == STAT_FULL || status == STAT_EMPTY)
    `PTPI_ASSERT_IMP(a_noseg, clk, rst_n, out_valid && segment == '1, position_out == '0 && velocity_out == '0 && accel_out == '0)
    `PTPI_ASSERT_IMP(a_empty, clk, rst_n, out_valid && status == STAT_EMPTY, total_period == '0 && segment == '1)

endmodule

bind path_time_param_interpolator ptpi_checker u_ptpi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .position_out (result.position_out),
    .velocity_out (result.velocity_out),
    .accel_out    (result.accel_out),
    .total_period (result.total_period),
    .segment      (result.segment),
    .status       (result.status)
);
`default_nettype wire

[sim/tb_path_time_param_interpolator.sv]
// Testbench for the path-time interpolator: directed and random pushes, queries, clears
`timescale 1ns / 1ps
`default_nettype none
module tb_path_time_param_interpolator;
    import ptpi_pkg::*;

    localparam int DEPTH = 64;
    localparam longint VHI = 64'sd2147483647;
    localparam longint VLO = -64'sd2147483648;
    localparam longint CYCLE_LIMIT = 64'd2000000;

    typedef struct packed {
        logic signed [31:0] position_out;
        logic signed [31:0] velocity_out;
        logic signed [31:0] accel_out;
        logic [30:0]        total_period;
        logic signed [7:0]  segment;
        logic [1:0]         status;
    } answer_t;

    logic clk;
    logic rst_n;
    ptpi_in_if  item ();
    ptpi_out_if result ();

    path_time_param_interpolator #(.MAX_POINTS(DEPTH)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .item(item.sink),
        .result(result.source)
    );

    longint wp_pos [DEPTH];
    longint wp_spd [DEPTH];
    longint wp_acc [DEPTH];
    longint wp_time [DEPTH];
    int     wp_count;
    answer_t expected_answers [$];
    int     mismatches = 0;
    longint cycles = 0;
    int     stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint clamp32(input longint x);
        if (x > VHI)
            return VHI;
        if (x < VLO)
            return VLO;
        return x;
    endfunction

    function automatic longint floor_div(input longint x, input int k);
        return x >>> k;
    endfunction

    function automatic longint int_root(input longint x);
        longint r;
        longint b;
        r = 0;
        for (b = 64'sd1 << 31; b > 0; b = b >> 1)
            if ((r + b) * (r + b) <= x)
                r = r + b;
        return r;
    endfunction

    function automatic longint last_stamp();
        if (wp_count == 0)
            return 0;
        return wp_time[wp_count-1] < 0 ? 0 : wp_time[wp_count-1];
    endfunction

    function automatic answer_t interpolate(input kind_t k, input logic signed [31:0] s_in,
                                            input logic signed [31:0] x_in,
                                            input logic signed [31:0] u_in,
                                            input logic signed [31:0] tq_in);
        answer_t a;
        longint pos, vel, acc, seg, v, t, ds, vsum, mag, dt, tq, last, sq, dt2, i;
        int j;
        pos = 0; vel = 0; acc = 0; seg = -1;
        a.status = STAT_OK;
        if (k == KIND_CLEAR)
            wp_count = 0;
        else if (k == KIND_PUSH)
        begin
            if (wp_count >= DEPTH)
                a.status = STAT_FULL;
            else
            begin
                v = 1;
                t = 0;
                if (x_in > 0)
                begin
                    v = int_root(longint'(x_in) <<< 16);
                    if (v < 1)
                        v = 1;
                end
                if (wp_count > 0)
                begin
                    ds = longint'(s_in) - wp_pos[wp_count-1];
                    vsum = wp_spd[wp_count-1] + v;
                    mag = (ds < 0 ? -ds : ds) <<< 17;
                    dt = mag / vsum;
                    if (ds < 0)
                        dt = -dt;
                    t = clamp32(wp_time[wp_count-1] + dt);
                end
                wp_pos[wp_count] = s_in;
                wp_spd[wp_count] = v;
                wp_acc[wp_count] = u_in;
                wp_time[wp_count] = t;
                wp_count++;
            end
        end
        else if (k == KIND_QUERY)
        begin
            if (wp_count == 0)
                a.status = STAT_EMPTY;
            else
            begin
                tq = tq_in;
                i = -1;
                last = wp_count - 1;
                for (j = 0; j < wp_count; j++)
                begin
                    if (wp_time[j] > tq)
                        break;
                    i++;
                end
                seg = i;
                if (i >= 0 && i < last)
                begin
                    dt = clamp32(tq - wp_time[i]);
                    sq = dt < 0 ? -dt : dt;
                    sq = longint'((64'(sq) * 64'(sq)) >> 16);
                    dt2 = sq > VHI ? VHI : sq;
                    pos = clamp32(wp_pos[i] + floor_div(wp_spd[i] * dt, 16)
                                  + floor_div(wp_acc[i] * dt2, 17));
                    vel = clamp32(wp_spd[i] + floor_div(wp_acc[i] * dt, 16));
                    acc = wp_acc[i];
                end
                else if (i >= last)
                    pos = wp_pos[last];
            end
        end
        a.position_out = pos[31:0];
        a.velocity_out = vel[31:0];
        a.accel_out = acc[31:0];
        a.total_period = PER_W'(last_stamp());
        a.segment = seg[7:0];
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_beat(input kind_t k, input logic signed [31:0] s,
                             input logic signed [31:0] x, input logic signed [31:0] u,
                             input logic signed [31:0] tq);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            item.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        item.valid <= 1'b1;
        item.kind <= k;
        item.waypoint_position <= s;
        item.speed_squared <= x;
        item.waypoint_accel <= u;
        item.query_time <= tq;
        expected_answers = {expected_answers, interpolate(k, s, x, u, tq)};
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rnd_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return $urandom_range(0, 32'h0020_0000);
        endcase
    endfunction

    // query time near one of the current stamps, or a random word
    function automatic logic signed [31:0] rnd_time();
        longint t;
        if (wp_count == 0 || $urandom_range(0, 4) == 0)
            return rnd_word();
        t = wp_time[$urandom_range(0, wp_count-1)];
        t = t + $signed($urandom_range(0, 32'h0004_0000)) - 64'sh0002_0000;
        return 32'(clamp32(t));
    endfunction

    task automatic test_directed();
        send_beat(KIND_QUERY, 0, 0, 0, 0);
        send_beat(KIND_NONE, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_beat(KIND_PUSH, 0, 32'sh0001_0000, 32'sh0000_8000, 0);
        send_beat(KIND_PUSH, 32'sh0002_0000, 0, 32'sh8000_0000, 0);
        send_beat(KIND_PUSH, 32'sh0001_0000, -32'sd5, 32'sh7fff_ffff, 0);
        send_beat(KIND_PUSH, 32'sh7fff_ffff, 32'sh7fff_ffff, -32'sd1, 0);
        send_beat(KIND_PUSH, 32'sh8000_0000, 32'sd1, 0, 0);
        send_beat(KIND_QUERY, 0, 0, 0, 32'sh8000_0000);
        send_beat(KIND_QUERY, 0, 0, 0, 0);
        send_beat(KIND_QUERY, 0, 0, 0, 32'sh0000_8000);
        send_beat(KIND_QUERY, 0, 0, 0, 32'sh0002_0000);
        send_beat(KIND_QUERY, 0, 0, 0, 32'sh7fff_ffff);
        send_beat(KIND_QUERY, 0, 0, 0, -32'sd1);
        send_beat(KIND_CLEAR, 0, 0, 0, 0);
        send_beat(KIND_QUERY, 0, 0, 0, 32'sh0001_0000);
        send_beat(KIND_PUSH, 32'sh0001_0000, 32'sh0004_0000, 32'sh0001_0000, 0);
        send_beat(KIND_QUERY, 0, 0, 0, 32'sh0001_0000);
        send_beat(KIND_QUERY, 0, 0, 0, 32'sh8000_0000);
    endtask

    task automatic test_full_table();
        int n;
        send_beat(KIND_CLEAR, 0, 0, 0, 0);
        for (n = 0; n < DEPTH + 2; n++)
            send_beat(KIND_PUSH, n * 32'sh0001_0000, rnd_word(), rnd_word(), 0);
        send_beat(KIND_QUERY, 0, 0, 0, rnd_time());
        send_beat(KIND_QUERY, 0, 0, 0, 32'sh7fff_ffff);
    endtask

    task automatic test_random_paths();
        int n, len, q;
        longint s;
        for (n = 0; n < 37; n++)
        begin
            send_beat(KIND_CLEAR, rnd_word(), rnd_word(), rnd_word(), rnd_word());
            len = $urandom_range(1, 8);
            s = rnd_word();
            for (q = 0; q < len; q++)
            begin
                if ($urandom_range(0, 9) == 0)
                    s = rnd_word();
                else
                    s = clamp32(s + $urandom_range(0, 32'h0003_0000)
                                - ($urandom_range(0, 5) == 0 ? 64'sh0002_0000 : 0));
                send_beat(KIND_PUSH, 32'(s), rnd_word(), rnd_word(), rnd_word());
            end
            len = $urandom_range(4, 10);
            for (q = 0; q < len; q++)
                send_beat($urandom_range(0, 19) == 0 ? KIND_NONE : KIND_QUERY,
                          rnd_word(), rnd_word(), rnd_word(), rnd_time());
        end
    endtask

    // drains result beats with random back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result.ready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            result.ready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        answer_t got, want;
        if (rst_n && result.valid && result.ready)
        begin
            got.position_out = result.position_out;
            got.velocity_out = result.velocity_out;
            got.accel_out = result.accel_out;
            got.total_period = result.total_period;
            got.segment = result.segment;
            got.status = result.status;
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", got);
            end
            else
            begin
                want = expected_answers.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        wp_count = 0;
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.kind = KIND_NONE;
        item.waypoint_position = '0;
        item.speed_squared = '0;
        item.waypoint_accel = '0;
        item.query_time = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_full_table();
        test_random_paths();
        item.valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
